// ===== src/dgsp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dgsp_pkg;

   // Width of a summed ear gain: up to eight sources of Q1.16 each
   localparam int GAIN_W = 20;

   // Register indexes of the csr port
   localparam logic REG_BASE_ANGLE = 1'b0;
   localparam logic REG_RADIUS     = 1'b1;

   // Rotation steps and fixed constants of the source placement
   localparam int          CORDIC_STEPS = 16;
   localparam logic [29:0] CORDIC_GAIN  = 30'd652032874;
   localparam logic [27:0] EAR_OFFSET   = 28'd241591910;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ANGLE,
      ST_SCALE,
      ST_ROTATE,
      ST_SQUARE_X,
      ST_SQUARE_Y,
      ST_ROOT,
      ST_PREP,
      ST_DIVIDE,
      ST_ACCUM,
      ST_FINISH
   } eng_state_type;

   typedef struct packed {
      logic signed [15:0] base_angle;
      logic [15:0]        radius;
   } cfg_type;

   typedef struct packed {
      logic [GAIN_W-1:0] gain_left;
      logic [GAIN_W-1:0] gain_right;
   } gains_type;

   // Arctangent of 2^-i, 2^32 per turn
   function automatic logic [31:0] atan_turn(input logic [3:0] idx);
      logic [31:0] val;
      case (idx)
         4'd0:    val = 32'h20000000;
         4'd1:    val = 32'h12E4051E;
         4'd2:    val = 32'h09FB385B;
         4'd3:    val = 32'h051111D4;
         4'd4:    val = 32'h028B0D43;
         4'd5:    val = 32'h0145D7E1;
         4'd6:    val = 32'h00A2F61E;
         4'd7:    val = 32'h00517C55;
         4'd8:    val = 32'h0028BE53;
         4'd9:    val = 32'h00145F2F;
         4'd10:   val = 32'h000A2F98;
         4'd11:   val = 32'h000517CC;
         4'd12:   val = 32'h00028BE6;
         4'd13:   val = 32'h000145F3;
         4'd14:   val = 32'h0000A2FA;
         4'd15:   val = 32'h0000517D;
         default: val = 32'h0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

// ===== src/distance_gain_stereo_panner.sv =====
`timescale 1ns / 1ps
`default_nettype none

// One sample per cycle while busy is low; each passes the sample, product, magnitude,
// quotient-estimate and output registers before rsp_strobe. The receiver cannot stall;
// every result is shown for exactly one cycle. Ear gains come from one shared unit
// (rotation, square root, division) that sweeps all sources and both ears and holds busy
// high meanwhile. Synchronous reset loads base_angle = 0 and radius = 1.0, then runs that
// sweep; every csr write starts it again.
module distance_gain_stereo_panner #(
   parameter int NUM_SOURCES  = 3,
   parameter int SAMPLE_WIDTH = 24
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic signed [SAMPLE_WIDTH-1:0]  req_sample_in,
   output logic                                 rsp_strobe,
   output logic signed [SAMPLE_WIDTH-1:0]       rsp_left_out,
   output logic signed [SAMPLE_WIDTH-1:0]       rsp_right_out,
   input  wire logic                            csr_write_enable,
   input  wire logic                            csr_index,
   input  wire logic [15:0]                     csr_write_data
);

   dgsp_pkg::cfg_type   cfg_ff, cfg_in;
   dgsp_pkg::gains_type gains;
   logic                accept;

   // Register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            dgsp_pkg::REG_BASE_ANGLE: cfg_in.base_angle = signed'(csr_write_data);
            dgsp_pkg::REG_RADIUS:     cfg_in.radius     = csr_write_data;
            default:                  cfg_in            = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_angle <= 16'sd0;
         cfg_ff.radius     <= 16'd4096;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign accept = start & ~busy;

   dgsp_gain_engine #(
      .NUM_SOURCES (NUM_SOURCES)
   ) u_engine (
      .clock (clock),
      .reset (reset),
      .kick  (csr_write_enable),
      .cfg   (cfg_ff),
      .busy  (busy),
      .gains (gains)
   );

   dgsp_scale_pipe #(
      .NUM_SOURCES  (NUM_SOURCES),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_pipe (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_sample (req_sample_in),
      .gains     (gains),
      .out_valid (rsp_strobe),
      .out_left  (rsp_left_out),
      .out_right (rsp_right_out)
   );

endmodule

`default_nettype wire

// ===== src/dgsp_gain_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dgsp_gain_engine #(
   parameter int NUM_SOURCES = 3
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               kick,
   input  wire dgsp_pkg::cfg_type  cfg,
   output logic                    busy,
   output dgsp_pkg::gains_type     gains
);

   localparam int IDX_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
   localparam logic [IDX_W-1:0] LAST_SRC = IDX_W'(NUM_SOURCES - 1);
   localparam logic signed [33:0] QUARTER = 34'sd1073741824;
   localparam logic signed [33:0] HALF    = 34'sd2147483648;

   dgsp_pkg::eng_state_type state_ff, state_in;

   logic [IDX_W-1:0]             src_ff, src_in;
   logic                         ear_ff, ear_in;
   logic [4:0]                   step_ff, step_in;
   logic [15:0]                  mag_ff, mag_in;
   logic signed [33:0]           z_ff, z_in;
   logic signed [35:0]           x_ff, x_in, y_ff, y_in;
   logic [42:0]                  v_ff, v_in, res_ff, res_in, bit_ff, bit_in;
   logic [20:0]                  num_ff, num_in;
   logic [25:0]                  den_ff, den_in, rem_ff, rem_in;
   logic [16:0]                  quo_ff, quo_in;
   logic [dgsp_pkg::GAIN_W-1:0]  acc_l_ff, acc_l_in, acc_r_ff, acc_r_in;
   dgsp_pkg::gains_type          gains_ff, gains_in;

   logic [15:0]        src_offset;
   logic [15:0]        raw_angle;
   logic [16:0]        ang_ext, mag17;
   logic [45:0]        scale_prod;
   logic signed [35:0] dx, dy;
   logic signed [33:0] at;
   logic signed [36:0] ear_term, xoff;
   logic signed [21:0] xo, yo;
   logic signed [43:0] sq_x, sq_y;
   logic [43:0]        trial;
   logic [16:0]        k0;
   logic [26:0]        rem_sh;

   // Next state
   always_comb begin
      state_in = state_ff;
      if (kick) begin
         state_in = dgsp_pkg::ST_ANGLE;
      end else begin
         case (state_ff)
            dgsp_pkg::ST_IDLE:     state_in = dgsp_pkg::ST_IDLE;
            dgsp_pkg::ST_ANGLE:    state_in = dgsp_pkg::ST_SCALE;
            dgsp_pkg::ST_SCALE:    state_in = dgsp_pkg::ST_ROTATE;
            dgsp_pkg::ST_ROTATE: begin
               if (step_ff == 5'(dgsp_pkg::CORDIC_STEPS - 1)) state_in = dgsp_pkg::ST_SQUARE_X;
            end
            dgsp_pkg::ST_SQUARE_X: state_in = dgsp_pkg::ST_SQUARE_Y;
            dgsp_pkg::ST_SQUARE_Y: state_in = dgsp_pkg::ST_ROOT;
            dgsp_pkg::ST_ROOT: begin
               if (bit_ff[0]) state_in = dgsp_pkg::ST_PREP;
            end
            dgsp_pkg::ST_PREP:     state_in = dgsp_pkg::ST_DIVIDE;
            dgsp_pkg::ST_DIVIDE: begin
               if (step_ff == 5'd0) state_in = dgsp_pkg::ST_ACCUM;
            end
            dgsp_pkg::ST_ACCUM: begin
               if (!ear_ff) state_in = dgsp_pkg::ST_SQUARE_X;
               else if (src_ff == LAST_SRC) state_in = dgsp_pkg::ST_FINISH;
               else state_in = dgsp_pkg::ST_ANGLE;
            end
            dgsp_pkg::ST_FINISH:   state_in = dgsp_pkg::ST_IDLE;
            default:               state_in = dgsp_pkg::ST_IDLE;
         endcase
      end
   end

   // Outputs
   always_comb begin
      case (state_ff)
         dgsp_pkg::ST_IDLE: busy = 1'b0;
         default:           busy = 1'b1;
      endcase
   end

   assign gains = gains_ff;

   // Shared datapath terms
   always_comb begin
      // pick the fixed angle offset of the current source
      src_offset = '0;
      for (int j = 0; j < NUM_SOURCES; j++) begin
         if (src_ff == IDX_W'(j)) src_offset = 16'((j * 65536) / NUM_SOURCES);
      end
      raw_angle  = cfg.base_angle + src_offset;
      ang_ext    = {raw_angle[15], raw_angle};
      mag17      = raw_angle[15] ? (17'd0 - ang_ext) : ang_ext;
      scale_prod = 46'(cfg.radius) * 46'(dgsp_pkg::CORDIC_GAIN);
      dx         = y_ff >>> step_ff[3:0];
      dy         = x_ff >>> step_ff[3:0];
      at         = signed'({2'b00, dgsp_pkg::atan_turn(step_ff[3:0])});
      ear_term   = ear_ff ? -signed'({9'd0, dgsp_pkg::EAR_OFFSET})
                          : signed'({9'd0, dgsp_pkg::EAR_OFFSET});
      xoff       = {y_ff[35], y_ff} + ear_term;
      xo         = xoff[33:12];
      yo         = x_ff[33:12];
      sq_x       = xo * xo;
      sq_y       = yo * yo;
      trial      = {1'b0, res_ff} + {1'b0, bit_ff};
      k0         = ear_ff ? (17'd32768 - 17'(mag_ff)) : (17'd32768 + 17'(mag_ff));
      rem_sh     = {rem_ff, (step_ff == 5'd16) ? num_ff[0] : 1'b0};
   end

   // Datapath next values
   always_comb begin
      src_in   = src_ff;
      ear_in   = ear_ff;
      step_in  = step_ff;
      mag_in   = mag_ff;
      z_in     = z_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      v_in     = v_ff;
      res_in   = res_ff;
      bit_in   = bit_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      acc_l_in = acc_l_ff;
      acc_r_in = acc_r_ff;
      gains_in = gains_ff;
      case (state_ff)
         dgsp_pkg::ST_ANGLE: begin
            mag_in = mag17[15:0];
            z_in   = {{2{raw_angle[15]}}, raw_angle, 16'd0};
            x_in   = signed'({4'd0, scale_prod[45:14]});
         end
         dgsp_pkg::ST_SCALE: begin
            // fold the back half circle onto the front
            if (z_ff > QUARTER) begin
               x_in = -x_ff;
               z_in = z_ff - HALF;
            end else if (z_ff < -QUARTER) begin
               x_in = -x_ff;
               z_in = z_ff + HALF;
            end
            y_in    = '0;
            step_in = '0;
            ear_in  = 1'b0;
         end
         dgsp_pkg::ST_ROTATE: begin
            if (!z_ff[33]) begin
               x_in = x_ff - dx;
               y_in = y_ff + dy;
               z_in = z_ff - at;
            end else begin
               x_in = x_ff + dx;
               y_in = y_ff - dy;
               z_in = z_ff + at;
            end
            step_in = step_ff + 5'd1;
         end
         dgsp_pkg::ST_SQUARE_X: begin
            v_in = sq_x[42:0];
         end
         dgsp_pkg::ST_SQUARE_Y: begin
            v_in   = v_ff + sq_y[42:0];
            res_in = '0;
            bit_in = 43'd1 << 42;
         end
         dgsp_pkg::ST_ROOT: begin
            // one result bit per cycle
            if ({1'b0, v_ff} >= trial) begin
               v_in   = v_ff - trial[42:0];
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
         end
         dgsp_pkg::ST_PREP: begin
            num_in  = 21'd65536 + 21'(k0) * 21'd19;
            den_in  = 26'(21'd65536 + 21'(k0) * 21'd19) + 26'(res_ff[20:0]) * 26'd20;
            rem_in  = 26'((21'd65536 + 21'(k0) * 21'd19) >> 1);
            quo_in  = '0;
            step_in = 5'd16;
         end
         dgsp_pkg::ST_DIVIDE: begin
            // restoring division, one quotient bit per cycle
            if (rem_sh >= {1'b0, den_ff}) begin
               rem_in = 26'(rem_sh - {1'b0, den_ff});
               quo_in = {quo_ff[15:0], 1'b1};
            end else begin
               rem_in = rem_sh[25:0];
               quo_in = {quo_ff[15:0], 1'b0};
            end
            step_in = step_ff - 5'd1;
         end
         dgsp_pkg::ST_ACCUM: begin
            if (!ear_ff) begin
               acc_l_in = acc_l_ff + dgsp_pkg::GAIN_W'(quo_ff);
               ear_in   = 1'b1;
            end else begin
               acc_r_in = acc_r_ff + dgsp_pkg::GAIN_W'(quo_ff);
               ear_in   = 1'b0;
               src_in   = src_ff + IDX_W'(1);
            end
         end
         dgsp_pkg::ST_FINISH: begin
            gains_in.gain_left  = acc_l_ff;
            gains_in.gain_right = acc_r_ff;
         end
         default: begin
         end
      endcase
      // restart the sweep on a register write
      if (kick) begin
         src_in   = '0;
         acc_l_in = '0;
         acc_r_in = '0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dgsp_pkg::ST_ANGLE;
         src_ff   <= '0;
         ear_ff   <= 1'b0;
         step_ff  <= '0;
         acc_l_ff <= '0;
         acc_r_ff <= '0;
      end else begin
         state_ff <= state_in;
         src_ff   <= src_in;
         ear_ff   <= ear_in;
         step_ff  <= step_in;
         acc_l_ff <= acc_l_in;
         acc_r_ff <= acc_r_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      mag_ff   <= mag_in;
      z_ff     <= z_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      v_ff     <= v_in;
      res_ff   <= res_in;
      bit_ff   <= bit_in;
      num_ff   <= num_in;
      den_ff   <= den_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      gains_ff <= gains_in;
   end

   a_busy_ends_at_finish: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> $past(state_ff == dgsp_pkg::ST_FINISH))
      else $error("busy dropped outside the finish step");

   a_root_bit_onehot: assert property (@(posedge clock) disable iff (reset)
      state_ff == dgsp_pkg::ST_ROOT |-> $onehot(bit_ff))
      else $error("square root trial bit lost");

   a_div_remainder: assert property (@(posedge clock) disable iff (reset)
      state_ff == dgsp_pkg::ST_DIVIDE |-> rem_ff < den_ff)
      else $error("division remainder out of range");

endmodule

`default_nettype wire

// ===== src/dgsp_scale_pipe.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dgsp_scale_pipe #(
   parameter int NUM_SOURCES  = 3,
   parameter int SAMPLE_WIDTH = 24
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            in_valid,
   input  wire logic signed [SAMPLE_WIDTH-1:0]  in_sample,
   input  wire dgsp_pkg::gains_type             gains,
   output logic                                 out_valid,
   output logic signed [SAMPLE_WIDTH-1:0]       out_left,
   output logic signed [SAMPLE_WIDTH-1:0]       out_right
);

   localparam int PW   = SAMPLE_WIDTH + dgsp_pkg::GAIN_W + 1;
   localparam int MW   = SAMPLE_WIDTH + 3;
   localparam int RSH  = MW + 1;
   localparam int CW   = MW + 4;
   localparam logic [RSH:0] RECIP = (RSH + 1)'((64'd1 << RSH) / NUM_SOURCES);
   localparam logic [CW-1:0] NSRC = CW'(NUM_SOURCES);

   logic [4:0] valid_ff;

   logic signed [SAMPLE_WIDTH-1:0]   sample_ff;
   logic [dgsp_pkg::GAIN_W-1:0]      lane_gain [2];
   logic signed [dgsp_pkg::GAIN_W:0] gain_s [2];
   logic signed [PW-1:0]             prod_in [2], prod_ff [2];
   logic [PW-1:0]                    absp [2];
   logic [MW-1:0]                    m3_in [2], m3_ff [2], m4_ff [2];
   logic                             neg3_ff [2], neg4_ff [2];
   logic [MW+RSH:0]                  recip_prod [2];
   logic [MW-1:0]                    qest_in [2], qest_ff [2];
   logic [CW-1:0]                    rem_chk [2];
   logic [MW-1:0]                    q_fix [2];
   logic [SAMPLE_WIDTH-1:0]          out_in [2], out_ff [2];

   assign lane_gain[0] = gains.gain_left;
   assign lane_gain[1] = gains.gain_right;

   // Per-lane arithmetic between the stage registers
   always_comb begin
      for (int c = 0; c < 2; c++) begin
         gain_s[c]     = signed'({1'b0, lane_gain[c]});
         prod_in[c]    = sample_ff * gain_s[c];
         absp[c]       = prod_ff[c][PW-1] ? unsigned'(-prod_ff[c]) : unsigned'(prod_ff[c]);
         m3_in[c]      = MW'(absp[c] >> 16);
         recip_prod[c] = (MW + RSH + 1)'(m3_ff[c]) * (MW + RSH + 1)'(RECIP);
         qest_in[c]    = MW'(recip_prod[c] >> RSH);
         rem_chk[c]    = CW'(m4_ff[c]) - CW'(qest_ff[c]) * NSRC;
         q_fix[c]      = (rem_chk[c] >= NSRC) ? (qest_ff[c] + MW'(1)) : qest_ff[c];
         out_in[c]     = neg4_ff[c] ? SAMPLE_WIDTH'(-q_fix[c]) : SAMPLE_WIDTH'(q_fix[c]);
      end
   end

   // Advance the valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[3:0], in_valid};
      end
   end

   // Stage registers
   always_ff @(posedge clock) begin
      sample_ff <= in_sample;
      for (int c = 0; c < 2; c++) begin
         prod_ff[c] <= prod_in[c];
         m3_ff[c]   <= m3_in[c];
         neg3_ff[c] <= prod_ff[c][PW-1];
         m4_ff[c]   <= m3_ff[c];
         neg4_ff[c] <= neg3_ff[c];
         qest_ff[c] <= qest_in[c];
         out_ff[c]  <= out_in[c];
      end
   end

   assign out_valid = valid_ff[4];
   assign out_left  = signed'(out_ff[0]);
   assign out_right = signed'(out_ff[1]);

   a_latency: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> $past(in_valid, 5))
      else $error("result without a matching transaction");

   a_quot_left: assert property (@(posedge clock) disable iff (reset)
      valid_ff[3] |-> rem_chk[0] < (NSRC << 1))
      else $error("left quotient estimate off by more than one");

   a_quot_right: assert property (@(posedge clock) disable iff (reset)
      valid_ff[3] |-> rem_chk[1] < (NSRC << 1))
      else $error("right quotient estimate off by more than one");

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;

   localparam int NSRC  = 3;
   localparam int SW    = 24;
   localparam int LIMIT = 5000;

   typedef struct {
      logic signed [SW-1:0] left;
      logic signed [SW-1:0] right;
   } pair_type;

   // Pan predictor and store of expected stereo pairs
   class pan_scoreboard;
      logic signed [15:0] base_angle;
      logic [15:0]        radius;
      longint unsigned    gain_l, gain_r;
      pair_type           pending[$];
      int                 mismatches;
      int                 errors;

      function new();
         base_angle = 0;
         radius     = 16'd4096;
         mismatches = 0;
         errors     = 0;
         update_gains();
      endfunction

      function longint unsigned int_sqrt(longint unsigned v);
         longint unsigned res, bitv;
         res  = 0;
         bitv = 64'd1 << 62;
         while (bitv > v) bitv = bitv >> 2;
         while (bitv != 0) begin
            if (v >= res + bitv) begin
               v   = v - (res + bitv);
               res = (res >> 1) + bitv;
            end else begin
               res = res >> 1;
            end
            bitv = bitv >> 2;
         end
         return res;
      endfunction

      function longint unsigned ear_gain(longint xoff, longint ypos, longint unsigned k0);
         longint          xo, yo;
         longint unsigned dist_v, num;
         xo     = xoff >>> 12;
         yo     = ypos >>> 12;
         dist_v = int_sqrt(longint'(xo * xo) + longint'(yo * yo));
         num    = 64'd65536 + 19 * k0;
         return (num << 16) / (num + 20 * dist_v);
      endfunction

      // Recompute the summed ear gains for the current placement
      function void update_gains();
         longint          atan_tab[16];
         longint          x, y, z, dx, dy, ear;
         longint unsigned off, mag;
         logic [15:0]     raw;
         logic signed [15:0] ang;
         atan_tab = '{64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
                      64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
                      64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
                      64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D};
         ear    = 64'd241591910;
         gain_l = 0;
         gain_r = 0;
         for (int j = 0; j < NSRC; j++) begin
            off = (64'd65536 * j) / NSRC;
            raw = 16'(base_angle + off);
            ang = raw;
            mag = (ang < 0) ? -longint'(ang) : longint'(ang);
            z   = longint'(ang) * 65536;
            x   = longint'(((64'(radius) << 16) * 64'd652032874) >> 30);
            y   = 0;
            if (z > 64'sd1073741824) begin
               x = -x;
               z = z - 64'sd2147483648;
            end else if (z < -64'sd1073741824) begin
               x = -x;
               z = z + 64'sd2147483648;
            end
            for (int i = 0; i < 16; i++) begin
               dx = y >>> i;
               dy = x >>> i;
               if (z >= 0) begin
                  x = x - dx;
                  y = y + dy;
                  z = z - atan_tab[i];
               end else begin
                  x = x + dx;
                  y = y - dy;
                  z = z + atan_tab[i];
               end
            end
            gain_l += ear_gain(y + ear, x, 64'd32768 + mag);
            gain_r += ear_gain(y - ear, x, 64'd32768 - mag);
         end
      endfunction

      function void write_reg(bit idx, logic [15:0] val);
         if (idx == dgsp_pkg::REG_BASE_ANGLE) base_angle = val;
         else radius = val;
         update_gains();
      endfunction

      // Note an accepted sample and queue its stereo pair
      function void note(logic signed [SW-1:0] smp);
         longint   s, dv;
         pair_type p;
         s  = smp;
         dv = longint'(NSRC) * 65536;
         p.left  = SW'((s * longint'(gain_l)) / dv);
         p.right = SW'((s * longint'(gain_r)) / dv);
         pending.push_back(p);
      endfunction

      // Compare a result transaction with the oldest expectation
      function void check(logic signed [SW-1:0] l, logic signed [SW-1:0] r);
         pair_type p;
         if (pending.size() == 0) begin
            errors++;
            if (mismatches++ < 10)
               $display("unexpected result left=%0d right=%0d", l, r);
            return;
         end
         p = pending.pop_front();
         if (p.left !== l || p.right !== r) begin
            errors++;
            if (mismatches++ < 10)
               $display("mismatch: expected left=%0d right=%0d, got left=%0d right=%0d",
                        p.left, p.right, l, r);
         end
      endfunction
   endclass

   logic                 clock = 0;
   logic                 reset = 1;
   logic                 start = 0;
   logic                 busy;
   logic signed [SW-1:0] req_sample_in = '0;
   logic                 rsp_strobe;
   logic signed [SW-1:0] rsp_left_out, rsp_right_out;
   logic                 csr_write_enable = 0;
   logic                 csr_index = 0;
   logic [15:0]          csr_write_data = '0;

   pan_scoreboard sb = new();
   int            quiet_cycles = 0;
   bit            no_idle = 0;

   distance_gain_stereo_panner #(.NUM_SOURCES(NSRC), .SAMPLE_WIDTH(SW)) u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_sample_in(req_sample_in), .rsp_strobe(rsp_strobe),
      .rsp_left_out(rsp_left_out), .rsp_right_out(rsp_right_out),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   // Track accepted transactions and results; watchdog on silence
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) sb.note(req_sample_in);
         if (rsp_strobe) sb.check(rsp_left_out, rsp_right_out);
         if ((start && !busy) || rsp_strobe) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= LIMIT) begin
            $display("simulation failed");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // Present one sample and hold it until accepted, with an optional idle burst
   task automatic send(logic signed [SW-1:0] smp);
      if (!no_idle && $urandom_range(0, 3) == 0) begin
         start = 0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      start         = 1;
      req_sample_in = smp;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      @(negedge clock);
      start = 0;
   endtask

   // Write both registers once the block has drained
   task automatic set_placement(logic [15:0] ang, logic [15:0] rad);
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      csr_write_enable = 1;
      csr_index        = dgsp_pkg::REG_BASE_ANGLE;
      csr_write_data   = ang;
      sb.write_reg(dgsp_pkg::REG_BASE_ANGLE, ang);
      @(negedge clock);
      csr_index      = dgsp_pkg::REG_RADIUS;
      csr_write_data = rad;
      sb.write_reg(dgsp_pkg::REG_RADIUS, rad);
      @(negedge clock);
      csr_write_enable = 0;
   endtask

   function automatic logic signed [SW-1:0] rand_sample();
      case ($urandom_range(0, 7))
         0:       return {1'b0, {(SW-1){1'b1}}};
         1:       return {1'b1, {(SW-1){1'b0}}};
         2:       return SW'($signed($urandom_range(0, 64)) - 32);
         default: return SW'($urandom);
      endcase
   endfunction

   initial begin
      logic [15:0] ang, rad;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed: extreme samples at the reset placement
      send({1'b0, {(SW-1){1'b1}}});
      send({1'b1, {(SW-1){1'b0}}});
      send('0);
      send(-1);
      send(1);
      send(24'h555555);
      send(24'hAAAAAA);

      // Directed placements: half and quarter turns both ways, zero and oversize radius
      set_placement(16'h8000, 16'd4096);
      send({1'b0, {(SW-1){1'b1}}});
      send({1'b1, {(SW-1){1'b0}}});
      set_placement(16'h7FFF, 16'd40960);
      send({1'b0, {(SW-1){1'b1}}});
      send(-1);
      set_placement(16'h0000, 16'd0);
      send({1'b1, {(SW-1){1'b0}}});
      send(24'h123456);
      set_placement(16'h4000, 16'd3686);
      send({1'b0, {(SW-1){1'b1}}});
      send({1'b1, {(SW-1){1'b0}}});
      set_placement(16'hC000, 16'd65535);
      send({1'b0, {(SW-1){1'b1}}});
      send(24'hFEDCBA);

      // Random placements, each with a batch of random samples
      for (int ph = 0; ph < 8; ph++) begin
         ang = 16'($urandom);
         rad = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40960));
         set_placement(ang, rad);
         if (ph == 7) no_idle = 1;
         for (int n = 0; n < 75; n++) send(rand_sample());
      end

      while (sb.pending.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
